/* sv/bfvdsr_pkg.sv */
`timescale 1ns / 1ps

package bfvdsr_pkg;

    // Fixed field widths of the two channels and the plain_modulus register.
    localparam int COEFF_FIELD_W = 64;
    localparam int MSG_FIELD_W   = 32;
    localparam int PLAIN_REG_W   = 32;

    // Full quotient width of floor(N / q): the top bits beyond the numerator
    // are handled by a precomputed seed.
    localparam int QUOT_BITS = 128;

    // Configuration port.
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 4;
    localparam int REG_SEL_BIT = 3;

    typedef enum logic {
        REG_CIPHER = 1'b0,
        REG_PLAIN  = 1'b1
    } t_reg_sel;

    localparam logic [COEFF_FIELD_W-1:0] RESET_CIPHER = 64'd65537;
    localparam logic [PLAIN_REG_W-1:0]   RESET_PLAIN  = 32'd256;

    typedef struct packed {
        logic [COEFF_FIELD_W-1:0] coefficient;
        logic                     last_in;
    } t_in_beat;

    typedef struct packed {
        logic [MSG_FIELD_W-1:0] message_coeff;
        logic                   last_out;
    } t_out_beat;

endpackage

/* sv/bfvdsr_mult.sv */
`timescale 1ns / 1ps

// Numerator t*v + floor(q/2) in two stages: two narrow partial products,
// then one wide add.
module bfvdsr_mult #(
    parameter int CB = 64,
    parameter int PB = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [CB-1:0]       i_v,
    input  logic                i_last,
    input  logic [PB-1:0]       i_t,
    input  logic [CB-1:0]       i_q,
    output logic                o_valid,
    output logic [CB+PB:0]      o_num,
    output logic                o_last
);

    localparam int LO_W = (CB + 1) / 2;
    localparam int HI_W = CB - LO_W;
    localparam int PW0  = PB + LO_W;
    localparam int PW1  = PB + HI_W;
    localparam int NB   = CB + PB + 1;

    logic           r_valid1;
    logic           r_last1;
    logic [PW0-1:0] r_p0;
    logic [PW1-1:0] r_p1;
    logic [CB-2:0]  r_half;
    logic           r_valid2;
    logic           r_last2;
    logic [NB-1:0]  r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0   <= PW0'(i_t) * PW0'(i_v[LO_W-1:0]);
        r_p1   <= PW1'(i_t) * PW1'(i_v[CB-1:LO_W]);
        r_half <= i_q[CB-1:1];
        r_last1 <= i_last;
        r_num  <= NB'(r_p0) + (NB'(r_p1) << LO_W) + NB'(r_half);
        r_last2 <= r_last1;
    end

    assign o_valid = r_valid2;
    assign o_num   = r_num;
    assign o_last  = r_last2;

endmodule

/* sv/bfvdsr_premod.sv */
`timescale 1ns / 1ps

// Seed (2^STEPS - 1) mod t, the quotient prefix when q is zero.
// One doubling step per cycle; busy until done.
module bfvdsr_premod #(
    parameter int PB    = 32,
    parameter int STEPS = 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic [PB-1:0] i_t,
    output logic [PB-1:0] o_pre,
    output logic          o_busy
);

    localparam int CNT_W = $clog2(STEPS + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [PB-1:0]    r_acc;
    logic [PB:0]      x;
    logic [PB:0]      t_ext;
    logic [PB:0]      x_sub;
    logic [PB-1:0]    n_acc;

    always_comb begin
        x     = {r_acc, 1'b1};
        t_ext = {1'b0, i_t};
        x_sub = x - t_ext;
        n_acc = (x >= t_ext) ? x_sub[PB-1:0] : x[PB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_load) begin
            r_cnt <= CNT_W'(STEPS);
            r_acc <= '0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            r_acc <= n_acc;
        end
    end

    assign o_pre  = r_acc;
    assign o_busy = (r_cnt != '0);

endmodule

/* sv/bfvdsr_cell.sv */
`timescale 1ns / 1ps

// One restoring-division step plus one step of the running mod-t reduction.
module bfvdsr_cell #(
    parameter int CB = 64,
    parameter int PB = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CB-1:0]    i_q,
    input  logic [PB-1:0]    i_t,
    input  logic             i_valid,
    input  logic [CB-1:0]    i_rem,
    input  logic [CB+PB:0]   i_num,
    input  logic [PB-1:0]    i_acc,
    input  logic             i_last,
    output logic             o_valid,
    output logic [CB-1:0]    o_rem,
    output logic [CB+PB:0]   o_num,
    output logic [PB-1:0]    o_acc,
    output logic             o_last
);

    localparam int NB = CB + PB + 1;

    logic [CB:0]   s;
    logic [CB:0]   q_ext;
    logic [CB:0]   s_sub;
    logic          qb;
    logic [PB:0]   x;
    logic [PB:0]   t_ext;
    logic [PB:0]   x_sub;
    logic [CB-1:0] n_rem;
    logic [PB-1:0] n_acc;
    logic [NB-1:0] n_num;

    logic          r_valid;
    logic [CB-1:0] r_rem;
    logic [NB-1:0] r_num;
    logic [PB-1:0] r_acc;
    logic          r_last;

    always_comb begin
        s     = {i_rem, i_num[NB-1]};
        q_ext = {1'b0, i_q};
        s_sub = s - q_ext;
        qb    = (s >= q_ext);
        n_rem = qb ? s_sub[CB-1:0] : s[CB-1:0];
        x     = {i_acc, qb};
        t_ext = {1'b0, i_t};
        x_sub = x - t_ext;
        n_acc = (x >= t_ext) ? x_sub[PB-1:0] : x[PB-1:0];
        n_num = {i_num[NB-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_num  <= n_num;
        r_acc  <= n_acc;
        r_last <= i_last;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_acc   = r_acc;
    assign o_last  = r_last;

endmodule

/* sv/bfv_decrypt_scale_round.sv */
`timescale 1ns / 1ps

// Channel   | Signals                                     | Beat taken when
// ----------+---------------------------------------------+--------------------------------
// input     | start, busy, i_data (coefficient, last_in)  | start && !busy at clock edge
// result    | o_valid, o_data (message_coeff, last_out)   | o_valid high, one cycle only
// config    | psel, penable, pwrite, paddr, pwdata,       | psel && penable && pwrite
//           | prdata, pready (always high)                |   && pready
//
// One coefficient beat per cycle, back to back, while busy is low. Each beat
// passes two numerator stages, one division cell per numerator bit, and the
// output register. busy is high after reset and after every plain_modulus
// write, while the zero-modulus seed is formed.
// Reset is synchronous, active low. Results cannot be stalled by the receiver.
module bfv_decrypt_scale_round #(
    parameter int COEFF_BITS = 64,
    parameter int PLAIN_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  bfvdsr_pkg::t_in_beat                 i_data,
    output logic                                 o_valid,
    output bfvdsr_pkg::t_out_beat                o_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bfvdsr_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [bfvdsr_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [bfvdsr_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                 pready
);

    localparam int CB        = COEFF_BITS;
    localparam int PB        = PLAIN_BITS;
    localparam int NUM_BITS  = CB + PB + 1;
    // quotient bits above the numerator: zero unless q is zero, then all ones
    localparam int PRE_STEPS = bfvdsr_pkg::QUOT_BITS - NUM_BITS;

    // ---------------- configuration registers ----------------
    logic [bfvdsr_pkg::COEFF_FIELD_W-1:0] r_q;
    logic [bfvdsr_pkg::PLAIN_REG_W-1:0]   r_t;
    logic                                 cfg_wr;
    bfvdsr_pkg::t_reg_sel                 cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = bfvdsr_pkg::t_reg_sel'(paddr[bfvdsr_pkg::REG_SEL_BIT]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= bfvdsr_pkg::RESET_CIPHER;
            r_t <= bfvdsr_pkg::RESET_PLAIN;
        end else if (cfg_wr) begin
            case (cfg_sel)
                bfvdsr_pkg::REG_CIPHER: begin
                    r_q <= pwdata;
                end
                bfvdsr_pkg::REG_PLAIN: begin
                    r_t <= pwdata[bfvdsr_pkg::PLAIN_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            bfvdsr_pkg::REG_CIPHER: prdata = r_q;
            bfvdsr_pkg::REG_PLAIN:  prdata = bfvdsr_pkg::CFG_DATA_W'(r_t);
            default:                prdata = '0;
        endcase
    end

    // working moduli, narrowed to the configured widths
    logic [CB-1:0] q;
    logic [PB-1:0] t;
    logic          q_zero;
    logic          t_zero;

    assign q      = r_q[CB-1:0];
    assign t      = r_t[PB-1:0];
    assign q_zero = (q == '0);
    assign t_zero = (t == '0);

    // ---------------- zero-modulus seed ----------------
    logic [PB-1:0] pre;
    logic          pre_load;

    assign pre_load = cfg_wr && (cfg_sel == bfvdsr_pkg::REG_PLAIN);

    bfvdsr_premod #(
        .PB    (PB),
        .STEPS (PRE_STEPS)
    ) u_premod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (pre_load),
        .i_t     (t),
        .o_pre   (pre),
        .o_busy  (busy)
    );

    // ---------------- numerator stages ----------------
    logic                in_accept;
    logic [NUM_BITS:0]   c_valid;
    logic                c_last [0:NUM_BITS];
    logic [CB-1:0]       c_rem  [0:NUM_BITS];
    logic [NUM_BITS-1:0] c_num  [0:NUM_BITS];
    logic [PB-1:0]       c_acc  [0:NUM_BITS];

    assign in_accept = start && !busy;

    bfvdsr_mult #(
        .CB (CB),
        .PB (PB)
    ) u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_accept),
        .i_v     (i_data.coefficient[CB-1:0]),
        .i_last  (i_data.last_in),
        .i_t     (t),
        .i_q     (q),
        .o_valid (c_valid[0]),
        .o_num   (c_num[0]),
        .o_last  (c_last[0])
    );

    // chain head: empty remainder, accumulator seeded with the quotient prefix
    assign c_rem[0] = '0;
    assign c_acc[0] = q_zero ? pre : '0;

    // ---------------- division cell chain ----------------
    // cell k forms quotient bit NUM_BITS-1-k and folds it into acc mod t
    for (genvar k = 0; k < NUM_BITS; k++) begin : g_cell
        bfvdsr_cell #(
            .CB (CB),
            .PB (PB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_q     (q),
            .i_t     (t),
            .i_valid (c_valid[k]),
            .i_rem   (c_rem[k]),
            .i_num   (c_num[k]),
            .i_acc   (c_acc[k]),
            .i_last  (c_last[k]),
            .o_valid (c_valid[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_num   (c_num[k+1]),
            .o_acc   (c_acc[k+1]),
            .o_last  (c_last[k+1])
        );
    end

    // ---------------- output register ----------------
    logic                  r_out_valid;
    bfvdsr_pkg::t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= c_valid[NUM_BITS];
        end
    end

    // zero plain modulus forces a zero message
    always_ff @(posedge i_clk) begin
        r_out.message_coeff <= t_zero ? '0
                             : bfvdsr_pkg::MSG_FIELD_W'(c_acc[NUM_BITS]);
        r_out.last_out      <= c_last[NUM_BITS];
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
